/* hdl/bxp_pkg.sv */
// Package for the binary XNOR/popcount two-layer unit.
// Holds the register map, reset values, config struct and the fire function.
// No dependencies; used by every other file of the block.
package bxp_pkg;

    localparam int BYTE_W   = 8;
    localparam int NUM_W    = 4;
    localparam int THR_W    = 4;
    localparam int GROUP_W  = 64;
    localparam int DEC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZERO     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 3'd4;

    localparam logic [BYTE_W-1:0] RST_WEIGHT_ZERO  = 8'h69;
    localparam logic [BYTE_W-1:0] RST_WEIGHT_ONE   = 8'h96;
    localparam logic [BYTE_W-1:0] RST_WEIGHT_TWO   = 8'h51;
    localparam logic [BYTE_W-1:0] RST_WEIGHT_THREE = 8'ha9;
    localparam logic [THR_W-1:0]  RST_THRESHOLD    = 4'd4;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef struct packed {
        t_byte [NUM_W-1:0]  weight;
        logic [THR_W-1:0]   threshold;
    } t_cfg;

    // One binary neuron: count agreeing bits, compare against the threshold.
    function automatic logic fires(input t_byte x, input t_byte w,
                                   input logic [THR_W-1:0] thr);
        t_byte      agree;
        logic [3:0] cnt;
        agree = ~(x ^ w);
        cnt   = '0;
        for (int b = 0; b < BYTE_W; b++) begin
            cnt = cnt + {3'd0, agree[b]};
        end
        return (cnt >= thr);
    endfunction

endpackage

/* hdl/bxp_in_if.sv */
// Input channel of the binary XNOR/popcount unit: valid/ready plus both groups.
// Depends on bxp_pkg for the field widths.
interface bxp_in_if;
    logic                          valid;
    logic                          ready;
    logic [bxp_pkg::GROUP_W-1:0]   group_a;
    logic [bxp_pkg::GROUP_W-1:0]   group_b;

    modport source (output valid, output group_a, output group_b, input ready);
    modport sink   (input valid, input group_a, input group_b, output ready);
endinterface

/* hdl/bxp_out_if.sv */
// Output channel of the binary XNOR/popcount unit: valid/ready plus decision bits.
// Depends on bxp_pkg for the field width.
interface bxp_out_if;
    logic                        valid;
    logic                        ready;
    logic [bxp_pkg::DEC_W-1:0]   decision_bits;

    modport source (output valid, output decision_bits, input ready);
    modport sink   (input valid, input decision_bits, output ready);
endinterface

/* hdl/bxp_cfg_regs.sv */
// Configuration register file: four weight bytes and the match threshold.
// Depends on bxp_pkg for the register map and reset values.
module bxp_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bxp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bxp_pkg::CFG_DAT_W-1:0]   i_cfg_wdata,
    output bxp_pkg::t_cfg                   o_cfg
);

    bxp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.weight[0] <= bxp_pkg::RST_WEIGHT_ZERO;
            r_cfg.weight[1] <= bxp_pkg::RST_WEIGHT_ONE;
            r_cfg.weight[2] <= bxp_pkg::RST_WEIGHT_TWO;
            r_cfg.weight[3] <= bxp_pkg::RST_WEIGHT_THREE;
            r_cfg.threshold <= bxp_pkg::RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bxp_pkg::REG_WEIGHT_ZERO:     r_cfg.weight[0] <= i_cfg_wdata;
                bxp_pkg::REG_WEIGHT_ONE:      r_cfg.weight[1] <= i_cfg_wdata;
                bxp_pkg::REG_WEIGHT_TWO:      r_cfg.weight[2] <= i_cfg_wdata;
                bxp_pkg::REG_WEIGHT_THREE:    r_cfg.weight[3] <= i_cfg_wdata;
                bxp_pkg::REG_MATCH_THRESHOLD:
                    r_cfg.threshold <= i_cfg_wdata[bxp_pkg::THR_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/bxp_layer_one.sv */
// First layer: 64 XNOR/popcount neurons forming the eight hidden bytes.
// Depends on bxp_pkg for the config struct and the fire function.
module bxp_layer_one (
    input  logic [bxp_pkg::GROUP_W-1:0]   i_group_a,
    input  logic [bxp_pkg::GROUP_W-1:0]   i_group_b,
    input  bxp_pkg::t_cfg                 i_cfg,
    output bxp_pkg::t_byte [7:0]          o_hidden
);

    always_comb begin
        for (int k = 0; k < bxp_pkg::NUM_W; k++) begin
            for (int i = 0; i < 8; i++) begin
                o_hidden[k][i] = bxp_pkg::fires(i_group_a[8*i +: 8],
                                                i_cfg.weight[k], i_cfg.threshold);
                o_hidden[k+4][i] = bxp_pkg::fires(i_group_b[8*i +: 8],
                                                  i_cfg.weight[k], i_cfg.threshold);
            end
        end
    end

endmodule

/* hdl/bxp_layer_two.sv */
// Second layer: threshold each hidden byte against the inverted weight parity.
// Depends on bxp_pkg for the config struct and the fire function.
module bxp_layer_two (
    input  bxp_pkg::t_byte [7:0]          i_hidden,
    input  bxp_pkg::t_cfg                 i_cfg,
    output logic [bxp_pkg::DEC_W-1:0]     o_decision
);

    bxp_pkg::t_byte inv_parity;
    bxp_pkg::t_byte straight;

    assign inv_parity = ~(i_cfg.weight[0] ^ i_cfg.weight[1]
                          ^ i_cfg.weight[2] ^ i_cfg.weight[3]);

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            straight[i] = bxp_pkg::fires(i_hidden[i], inv_parity, i_cfg.threshold);
        end
    end

    // High byte sees the hidden bytes rotated by four: same neurons, swapped nibbles.
    assign o_decision = {straight[3:0], straight[7:4], straight};

endmodule

/* hdl/binary_xnor_popcount_two_layer_unit.sv */
// Binary XNOR/popcount two-layer unit, top level.
// Path: an accepted word is captured in the input register, then moves into the result
// register; o_word.ready low holds it there. Both layers sit between the two registers.
// Throughput: one word per cycle unless o_word.ready stalls the output.
// Reset (i_rst_n, synchronous, active low): pipeline empties, weights and
// threshold return to their defaults. Depends on bxp_pkg, bxp_in_if, bxp_out_if.
module binary_xnor_popcount_two_layer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bxp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bxp_pkg::CFG_DAT_W-1:0]   i_cfg_wdata,
    bxp_in_if.sink                          i_word,
    bxp_out_if.source                       o_word
);

    bxp_pkg::t_cfg                  cfg;
    bxp_pkg::t_byte [7:0]           hidden;
    logic [bxp_pkg::DEC_W-1:0]      n_decision;

    // Input register stage
    logic                           r_in_vld;
    logic [bxp_pkg::GROUP_W-1:0]    r_group_a;
    logic [bxp_pkg::GROUP_W-1:0]    r_group_b;

    // Result register stage
    logic                           r_out_vld;
    logic [bxp_pkg::DEC_W-1:0]      r_decision;

    logic out_free;   // result register can take a new word this cycle
    logic advance;    // input stage moves into the result register

    assign out_free     = !r_out_vld || o_word.ready;
    assign advance      = r_in_vld && out_free;
    assign i_word.ready = !r_in_vld || out_free;

    bxp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_cfg      (cfg)
    );

    // Capture an accepted word; hold it while the result side is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_word.ready) begin
            r_in_vld <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_group_a <= i_word.group_a;
            r_group_b <= i_word.group_b;
        end
    end

    bxp_layer_one u_l1 (
        .i_group_a(r_group_a),
        .i_group_b(r_group_b),
        .i_cfg    (cfg),
        .o_hidden (hidden)
    );

    bxp_layer_two u_l2 (
        .i_hidden  (hidden),
        .i_cfg     (cfg),
        .o_decision(n_decision)
    );

    // Result register: load on advance, drop valid once taken with nothing behind.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_decision <= n_decision;
        end
    end

    assign o_word.valid         = r_out_vld;
    assign o_word.decision_bits = r_decision;

    // A word leaving the input stage always lands in the result register.
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_word.valid)
        else $error("advanced word did not reach the result register");

    // High byte is the straight byte with the hidden bytes rotated by four.
    a_rotated_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.decision_bits[11:8] == o_word.decision_bits[7:4])
                         && (o_word.decision_bits[15:12] == o_word.decision_bits[3:0]))
        else $error("rotated high byte disagrees with straight byte");

    // Zero threshold makes every neuron fire.
    a_thr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && cfg.threshold == '0) |=> (o_word.decision_bits == '1))
        else $error("zero threshold did not yield all ones");

    // Threshold above eight can never be reached.
    a_thr_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && cfg.threshold > 4'd8) |=> (o_word.decision_bits == '0))
        else $error("unreachable threshold produced a one");

endmodule
